// ----- src/msc_pkg.sv -----
package msc_pkg;

    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 16;
    localparam int MAX_ELEMS_DEF  = 64;

    // Sequencer states
    typedef enum logic [3:0] {
        S_LOAD,
        S_POP,
        S_PUSH_R,
        S_PUSH_L,
        S_MRD,
        S_MSTEP,
        S_CRD,
        S_CWR,
        S_ORD,
        S_OSEND
    } state_t;

    // Range stack operations
    typedef enum logic [1:0] {
        STK_NOP,
        STK_PUSH,
        STK_POP,
        STK_WRITE_TOP
    } stack_op_t;

    // Saturating increment of a count
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
    endfunction

endpackage

// ----- src/merge_sort_with_counts.sv -----
// Loads one value per cycle until an item marked last; further items stall meanwhile.
// Sort: each merge step is one RAM read then one compare/write, each merged element is
// then copied back by a read and a write, and each split range is marked and pushed as
// two halves. Each sorted result is read, then held on the output until it is taken.
// Reset (rst_n, asynchronous, active low) clears the sequencer, counts and
// the overflow flag; the element memories are not cleared.
module merge_sort_with_counts
    import msc_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic signed [DATA_W-1:0]  value,
    input  logic                      last,
    input  logic                      value_valid,
    output logic                      value_stall,
    output logic signed [DATA_W-1:0]  sorted_value,
    output logic                      end_of_set,
    output logic [COUNT_W-1:0]        compare_count,
    output logic [COUNT_W-1:0]        right_taken_count,
    output logic                      overflow,
    output logic                      result_valid,
    input  logic                      result_stall
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = AW + 1;

    state_t state_reg, state_next;

    logic [CW-1:0]      count_reg, count_next, count_after;
    logic [COUNT_W-1:0] cmp_reg, cmp_next;
    logic [COUNT_W-1:0] rt_reg, rt_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      lo_reg, lo_next, mid_reg, mid_next, hi_reg, hi_next;
    logic [CW-1:0]      i_reg, i_next, j_reg, j_next, k_reg, k_next;

    // Store and scratch memory ports
    logic              st_wr_en;
    logic [AW-1:0]     st_wr_addr, st_rd_a, st_rd_b;
    logic [DATA_W-1:0] st_wr_data, st_data_a, st_data_b;
    logic              sc_wr_en;
    logic [AW-1:0]     sc_wr_addr, sc_rd;
    logic [DATA_W-1:0] sc_wr_data, sc_data;

    // Range stack
    stack_op_t     stk_op;
    logic [AW-1:0] stk_push_lo, stk_push_hi, stk_top_lo, stk_top_hi;
    logic          stk_push_exp, stk_top_exp, stk_empty;

    logic [AW-1:0] top_mid;
    logic          left_ok, right_ok, take_left, in_acc, out_acc, is_end;

    assign count_after = (count_reg < CW'(MAX_ELEMS)) ? count_reg + CW'(1) : count_reg;
    assign top_mid     = stk_top_lo + ((stk_top_hi - stk_top_lo) >> 1);
    assign left_ok     = (i_reg <= {1'b0, mid_reg});
    assign right_ok    = (j_reg <= {1'b0, hi_reg});
    assign take_left   = ($signed(st_data_a) <= $signed(st_data_b));
    assign in_acc      = (state_reg == S_LOAD) && value_valid;
    assign out_acc     = (state_reg == S_OSEND) && !result_stall;
    assign is_end      = (k_reg == count_reg - CW'(1));

    msc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_store (
        .clk       (clk),
        .wr_en     (st_wr_en),
        .wr_addr   (st_wr_addr),
        .wr_data   (st_wr_data),
        .rd_addr_a (st_rd_a),
        .rd_addr_b (st_rd_b),
        .rd_data_a (st_data_a),
        .rd_data_b (st_data_b)
    );

    msc_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_scratch (
        .clk       (clk),
        .wr_en     (sc_wr_en),
        .wr_addr   (sc_wr_addr),
        .wr_data   (sc_wr_data),
        .rd_addr_a (sc_rd),
        .rd_addr_b (sc_rd),
        .rd_data_a (sc_data),
        .rd_data_b ()
    );

    msc_stack #(.MAX_ELEMS(MAX_ELEMS)) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (stk_op),
        .push_lo  (stk_push_lo),
        .push_hi  (stk_push_hi),
        .push_exp (stk_push_exp),
        .top_lo   (stk_top_lo),
        .top_hi   (stk_top_hi),
        .top_exp  (stk_top_exp),
        .empty    (stk_empty)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (value_valid && last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (stk_empty)
                begin
                    state_next = S_ORD;
                end
                else if (stk_top_lo < stk_top_hi)
                begin
                    state_next = stk_top_exp ? S_MRD : S_PUSH_R;
                end
            end
            S_PUSH_R: state_next = S_PUSH_L;
            S_PUSH_L: state_next = S_POP;
            S_MRD:    state_next = S_MSTEP;
            S_MSTEP:
            begin
                state_next = (k_reg == {1'b0, hi_reg}) ? S_CRD : S_MRD;
            end
            S_CRD:    state_next = S_CWR;
            S_CWR:
            begin
                state_next = (k_reg == {1'b0, hi_reg}) ? S_POP : S_CRD;
            end
            S_ORD:    state_next = S_OSEND;
            S_OSEND:
            begin
                if (!result_stall)
                begin
                    state_next = is_end ? S_LOAD : S_ORD;
                end
            end
            default:  state_next = S_LOAD;
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        count_next   = count_reg;
        cmp_next     = cmp_reg;
        rt_next      = rt_reg;
        ovf_next     = ovf_reg;
        lo_next      = lo_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        st_wr_en     = 1'b0;
        st_wr_addr   = k_reg[AW-1:0];
        st_wr_data   = sc_data;
        sc_wr_en     = 1'b0;
        sc_wr_addr   = k_reg[AW-1:0];
        sc_wr_data   = st_data_a;
        stk_op       = STK_NOP;
        stk_push_lo  = stk_top_lo;
        stk_push_hi  = stk_top_hi;
        stk_push_exp = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg < CW'(MAX_ELEMS))
                    begin
                        st_wr_en   = 1'b1;
                        st_wr_addr = count_reg[AW-1:0];
                        st_wr_data = value;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_after;
                    // Root range goes on the stack at end of set
                    if (last)
                    begin
                        stk_op      = STK_PUSH;
                        stk_push_lo = '0;
                        stk_push_hi = AW'(count_after - CW'(1));
                    end
                end
            end
            S_POP:
            begin
                k_next = '0;
                if (!stk_empty)
                begin
                    lo_next  = stk_top_lo;
                    mid_next = top_mid;
                    hi_next  = stk_top_hi;
                    if (stk_top_lo >= stk_top_hi)
                    begin
                        stk_op = STK_POP;
                    end
                    else if (stk_top_exp)
                    begin
                        // Both halves sorted: merge
                        stk_op = STK_POP;
                        i_next = {1'b0, stk_top_lo};
                        j_next = {1'b0, top_mid} + CW'(1);
                        k_next = {1'b0, stk_top_lo};
                    end
                    else
                    begin
                        stk_op       = STK_WRITE_TOP;
                        stk_push_exp = 1'b1;
                    end
                end
            end
            S_PUSH_R:
            begin
                stk_op      = STK_PUSH;
                stk_push_lo = mid_reg + AW'(1);
                stk_push_hi = hi_reg;
            end
            S_PUSH_L:
            begin
                stk_op      = STK_PUSH;
                stk_push_lo = lo_reg;
                stk_push_hi = mid_reg;
            end
            S_MSTEP:
            begin
                sc_wr_en = 1'b1;
                if (left_ok && right_ok)
                begin
                    cmp_next = sat_inc(cmp_reg);
                    if (take_left)
                    begin
                        i_next = i_reg + CW'(1);
                    end
                    else
                    begin
                        sc_wr_data = st_data_b;
                        j_next     = j_reg + CW'(1);
                        rt_next    = sat_inc(rt_reg);
                    end
                end
                else if (left_ok)
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    sc_wr_data = st_data_b;
                    j_next     = j_reg + CW'(1);
                end
                k_next = (k_reg == {1'b0, hi_reg}) ? {1'b0, lo_reg} : k_reg + CW'(1);
            end
            S_CWR:
            begin
                st_wr_en = 1'b1;
                k_next   = k_reg + CW'(1);
            end
            S_OSEND:
            begin
                if (out_acc)
                begin
                    k_next = k_reg + CW'(1);
                    if (is_end)
                    begin
                        count_next = '0;
                        cmp_next   = '0;
                        rt_next    = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                k_next = k_reg;
            end
        endcase
    end

    // Read addresses: merge pointers, or output index while emitting
    assign st_rd_a = (state_reg == S_ORD || state_reg == S_OSEND) ? k_reg[AW-1:0]
                                                                   : i_reg[AW-1:0];
    assign st_rd_b = j_reg[AW-1:0];
    assign sc_rd   = k_reg[AW-1:0];

    // Ports
    assign value_stall       = (state_reg != S_LOAD);
    assign result_valid      = (state_reg == S_OSEND);
    assign sorted_value      = st_data_a;
    assign end_of_set        = is_end;
    assign compare_count     = cmp_reg;
    assign right_taken_count = rt_reg;
    assign overflow          = ovf_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            cmp_reg   <= '0;
            rt_reg    <= '0;
            ovf_reg   <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cmp_reg   <= cmp_next;
            rt_reg    <= rt_next;
            ovf_reg   <= ovf_next;
            k_reg     <= k_next;
        end
    end

    // Range and merge pointers
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        mid_reg <= mid_next;
        hi_reg  <= hi_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
    end

endmodule

// ----- src/msc_ram.sv -----
module msc_ram
    import msc_pkg::*;
#(
    parameter int WIDTH = DATA_W,
    parameter int DEPTH = MAX_ELEMS_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- src/msc_stack.sv -----
module msc_stack
    import msc_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  stack_op_t                    op,
    input  logic [$clog2(MAX_ELEMS)-1:0] push_lo,
    input  logic [$clog2(MAX_ELEMS)-1:0] push_hi,
    input  logic                         push_exp,
    output logic [$clog2(MAX_ELEMS)-1:0] top_lo,
    output logic [$clog2(MAX_ELEMS)-1:0] top_hi,
    output logic                         top_exp,
    output logic                         empty
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int SD = 2 * AW + 2;
    localparam int PW = $clog2(SD + 1);
    localparam int IW = $clog2(SD);

    logic [AW-1:0] lo_reg  [SD];
    logic [AW-1:0] hi_reg  [SD];
    logic          exp_reg [SD];
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [IW-1:0] top_idx;
    logic [IW-1:0] wr_idx;
    logic          wr_en;

    assign top_idx = IW'(ptr_reg - PW'(1));
    assign empty   = (ptr_reg == '0);
    assign top_lo  = lo_reg[top_idx];
    assign top_hi  = hi_reg[top_idx];
    assign top_exp = exp_reg[top_idx];

    // Pointer and write control
    always_comb
    begin
        ptr_next = ptr_reg;
        wr_en    = 1'b0;
        wr_idx   = top_idx;
        case (op)
            STK_PUSH:
            begin
                ptr_next = ptr_reg + PW'(1);
                wr_en    = 1'b1;
                wr_idx   = IW'(ptr_reg);
            end
            STK_POP:
            begin
                ptr_next = ptr_reg - PW'(1);
            end
            STK_WRITE_TOP:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lo_reg[wr_idx]  <= push_lo;
            hi_reg[wr_idx]  <= push_hi;
            exp_reg[wr_idx] <= push_exp;
        end
    end

endmodule
